/* rtl/ird_pkg.sv */
// Shared types, constants and helpers of the integer to radix digit converter.
`default_nettype none

package ird_pkg;

   // Value width default and digit store geometry
   localparam int VALUE_WIDTH_DEFAULT = 64;
   localparam int STORE_DEPTH         = 64;
   localparam int STORE_AW            = $clog2(STORE_DEPTH);
   localparam int COUNT_W             = STORE_AW + 1;

   // Field widths
   localparam int RADIX_W = 5;
   localparam int DIGIT_W = 4;
   localparam int CHAR_W  = 8;

   // Quotient bits retired by the divider in one cycle
   localparam int STEP_BITS = 8;

   // Character and radix constants
   localparam logic [CHAR_W-1:0]  DIGIT_BASE_CHAR = 8'h30;
   localparam logic [RADIX_W-1:0] RADIX_RESET     = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN       = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX       = 5'd16;

   // Divider status toward the sequencer
   typedef struct packed {
      logic               done;
      logic [DIGIT_W-1:0] remainder;
   } div_result_type;

   // Clamp the programmed radix into the supported range
   function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      res = r;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/ird_divider.sv */
// Iterative divider by a small radix: STEP_BITS quotient bits per cycle.
`default_nettype none

module ird_divider
   import ird_pkg::*;
#(
   parameter int DIV_WIDTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_WIDTH-1:0] dividend,
   input  wire logic [RADIX_W-1:0]   radix,
   output      logic [DIV_WIDTH-1:0] quotient,
   output      div_result_type       result
);

   localparam int DIV_CYCLES = DIV_WIDTH / STEP_BITS;
   localparam int CNT_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

   logic [DIV_WIDTH-1:0] work_ff, work_in;
   logic [DIGIT_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   // Restoring long division, STEP_BITS dividend bits per cycle
   always_comb begin
      logic [RADIX_W-1:0] trial;
      rem_in  = rem_ff;
      work_in = work_ff;
      for (int i = 0; i < STEP_BITS; i++) begin
         trial   = {rem_in, work_in[DIV_WIDTH-1]};
         work_in = {work_in[DIV_WIDTH-2:0], 1'b0};
         if (trial >= radix) begin
            rem_in     = DIGIT_W'(trial - radix);
            work_in[0] = 1'b1;
         end else begin
            rem_in = trial[DIGIT_W-1:0];
         end
      end
   end

   // Control: load on start, count down the chunks, pulse done
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_CYCLES - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: quotient shifts in as dividend shifts out
   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= dividend;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   assign quotient         = work_ff;
   assign result.done      = done_ff;
   assign result.remainder = rem_ff;

endmodule

`default_nettype wire

/* rtl/ird_sequencer.sv */
// Conversion sequencer: sign handling, digit store and digit output.
`default_nettype none

module ird_sequencer
   import ird_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [RADIX_W-1:0]     radix,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic                   req_op,
   input  wire logic [VALUE_WIDTH-1:0] req_value,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [CHAR_W-1:0]      rsp_char_code,
   output      logic                   rsp_leading_minus,
   output      logic                   rsp_is_last
);

   localparam int DIV_WIDTH = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DIVIDE = 2'd1;
   localparam logic [1:0] S_READ   = 2'd2;
   localparam logic [1:0] S_SEND   = 2'd3;

   logic [1:0]             state_ff;
   logic [COUNT_W-1:0]     cnt_ff;
   logic [STORE_AW-1:0]    ptr_ff;
   logic                   neg_ff;
   logic                   first_ff;
   logic [DIGIT_W-1:0]     rd_ff;
   logic [DIGIT_W-1:0]     mem [STORE_DEPTH];

   logic                   accept;
   logic                   negative;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic                   div_start;
   logic [DIV_WIDTH-1:0]   div_dividend;
   logic [DIV_WIDTH-1:0]   div_quotient;
   div_result_type         div_res;
   logic                   last_digit;
   logic                   wr_en;
   logic                   rd_en;
   logic                   rsp_take;

   assign accept   = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // Negate a negative signed value; the most negative one stays as its magnitude
   assign negative  = req_op && req_value[VALUE_WIDTH-1];
   assign magnitude = negative ? (~req_value + 1'b1) : req_value;

   // Start a division on accept, and again while the quotient is nonzero and the store is not full
   assign last_digit   = (div_quotient == '0) || (cnt_ff == COUNT_W'(STORE_DEPTH - 1));
   assign wr_en        = (state_ff == S_DIVIDE) && div_res.done;
   assign div_start    = accept || (wr_en && !last_digit);
   assign div_dividend = accept ? DIV_WIDTH'(magnitude) : div_quotient;
   assign rd_en        = (state_ff == S_READ);

   ird_divider #(
      .DIV_WIDTH (DIV_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .radix    (radix),
      .quotient (div_quotient),
      .result   (div_res)
   );

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         ptr_ff   <= '0;
         neg_ff   <= 1'b0;
         first_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  neg_ff   <= negative;
                  cnt_ff   <= '0;
                  state_ff <= S_DIVIDE;
               end
            end
            S_DIVIDE: begin
               if (div_res.done) begin
                  if (last_digit) begin
                     ptr_ff   <= cnt_ff[STORE_AW-1:0];
                     first_ff <= 1'b1;
                     state_ff <= S_READ;
                  end else begin
                     cnt_ff <= cnt_ff + 1'b1;
                  end
               end
            end
            S_READ: begin
               state_ff <= S_SEND;
            end
            S_SEND: begin
               if (!rsp_stall) begin
                  first_ff <= 1'b0;
                  if (ptr_ff == '0) begin
                     state_ff <= S_IDLE;
                  end else begin
                     ptr_ff   <= ptr_ff - 1'b1;
                     state_ff <= S_READ;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Digit store: written least significant first, read back in reverse
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_ff[STORE_AW-1:0]] <= div_res.remainder;
      end
      if (rd_en) begin
         rd_ff <= mem[ptr_ff];
      end
   end

   // Result beat
   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = (state_ff == S_SEND);
   assign rsp_char_code     = DIGIT_BASE_CHAR + CHAR_W'(rd_ff);
   assign rsp_leading_minus = neg_ff && first_ff;
   assign rsp_is_last       = (ptr_ff == '0);

   // Assertions
   a_busy_while_sending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result beat is pending");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == S_DIVIDE))
      else $error("divider finished outside the divide phase");

   a_next_digit_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp_is_last) |=> (state_ff == S_READ))
      else $error("no store read after a non-final digit");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVIDE) |-> (cnt_ff < COUNT_W'(STORE_DEPTH)))
      else $error("digit count beyond the store depth");

endmodule

`default_nettype wire

/* rtl/integer_to_radix_digits.sv */
// Top level of the integer to radix digit converter.
//
// Usage: an input beat on req_ (req_op, req_value) is taken when req_valid
// is high and req_stall is low. req_op 0 treats the value as unsigned, 1 as
// two's complement. The magnitude is split into digits of the radix held in
// the csr_ register (written with csr_write_enable, clamped to 2..16). Each
// result beat on rsp_ carries one digit as '0'+digit, most significant first,
// with rsp_leading_minus on the first digit of a negative number and
// rsp_is_last on the final one. Zero gives a single '0'.
// Each digit costs one division in the shared divider, which retires eight
// quotient bits a cycle; the digits then leave through a store read state
// and then a send state each. One item is in flight at a time: req_stall
// stays high from acceptance until the last digit beat is taken. A stall on
// rsp_ holds the current beat unchanged. Reset clears the sequencer, the
// divider control and sets the radix to 10; the digit store needs no
// clearing.
`default_nettype none

module integer_to_radix_digits
   import ird_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [RADIX_W-1:0] csr_write_data,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic               req_op,
   input  wire logic [63:0]        req_value,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [CHAR_W-1:0]  rsp_char_code,
   output      logic               rsp_leading_minus,
   output      logic               rsp_is_last
);

   logic [RADIX_W-1:0] radix_ff;
   logic [RADIX_W-1:0] radix_eff;

   // Hold the radix register
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_write_enable) begin
         radix_ff <= csr_write_data;
      end
   end

   // Clamp to the supported range
   assign radix_eff = eff_radix(radix_ff);

   ird_sequencer #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_sequencer (
      .clock             (clock),
      .reset             (reset),
      .radix             (radix_eff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_value         (req_value[VALUE_WIDTH-1:0]),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_char_code     (rsp_char_code),
      .rsp_leading_minus (rsp_leading_minus),
      .rsp_is_last       (rsp_is_last)
   );

endmodule

`default_nettype wire

/* tb/integer_to_radix_digits_tb.sv */
// Self-checking testbench for the integer to radix digit converter.
module integer_to_radix_digits_tb;
   import ird_pkg::*;

   localparam logic OP_UNSIGNED = 1'b0;
   localparam logic OP_SIGNED   = 1'b1;
   localparam int   GAP_MAX        = 13;
   localparam int   WATCHDOG_LIMIT = 5000;
   localparam int   TAIL_CYCLES    = 32;
   localparam int   ITEMS_PER_PHASE = 13;

   typedef struct packed {
      logic        op;
      logic [63:0] value;
   } number_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              leading_minus;
      logic              is_last;
   } digit_beat_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [RADIX_W-1:0] csr_write_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_op = 1'b0;
   logic [63:0]        req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [CHAR_W-1:0]  rsp_char_code;
   logic               rsp_leading_minus;
   logic               rsp_is_last;

   number_type         pending_numbers[$];
   digit_beat_type     expected_digits[$];
   logic [RADIX_W-1:0] active_radix = RADIX_RESET;
   int                 error_count = 0;
   int                 idle_cycles = 0;
   int                 req_gap = 0;
   int                 rsp_hold = 0;
   bit                 req_calm = 1'b0;
   bit                 rsp_calm = 1'b0;

   integer_to_radix_digits uut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_char_code     (rsp_char_code),
      .rsp_leading_minus (rsp_leading_minus),
      .rsp_is_last       (rsp_is_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Split one number into digit beats, most significant first
   function automatic void predict_digits(input logic op, input logic [63:0] value,
                                          input logic [RADIX_W-1:0] radix);
      logic [3:0]     digits [0:63];
      logic [63:0]    magnitude;
      logic [63:0]    base;
      logic           negative;
      int             count;
      digit_beat_type beat;
      if (radix < RADIX_MIN) begin
         base = 64'(RADIX_MIN);
      end else if (radix > RADIX_MAX) begin
         base = 64'(RADIX_MAX);
      end else begin
         base = 64'(radix);
      end
      negative  = (op == OP_SIGNED) && value[63];
      magnitude = negative ? (~value + 64'd1) : value;
      count     = 0;
      do begin
         digits[count] = 4'(magnitude % base);
         magnitude     = magnitude / base;
         count++;
      end while (magnitude != 64'd0);
      for (int k = count - 1; k >= 0; k--) begin
         beat.char_code     = DIGIT_BASE_CHAR + {4'd0, digits[k]};
         beat.leading_minus = negative && (k == count - 1);
         beat.is_last       = (k == 0);
         expected_digits.push_back(beat);
      end
   endfunction

   // Draw a wait length; flip between busy and calm stretches now and then
   function automatic int draw_gap(inout bit calm);
      if ($urandom_range(0, 15) == 0) begin
         calm = !calm;
      end
      return calm ? 0 : $urandom_range(0, GAP_MAX);
   endfunction

   // Drive request beats from the pending queue, predicting each accepted one
   always @(posedge clock) begin : drive_requests
      number_type item;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_digits(req_op, req_value, active_radix);
         end
         if (!req_valid || !req_stall) begin
            if (req_gap != 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_numbers.size() != 0) begin
               item = pending_numbers.pop_front();
               req_op    <= item.op;
               req_value <= item.value;
               req_valid <= 1'b1;
               req_gap = draw_gap(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Take digit beats and compare them against the oldest expectation
   always @(posedge clock) begin : check_digits
      digit_beat_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_digits.size() == 0) begin
               $error("digit beat char_code %h with no expectation pending", rsp_char_code);
               error_count++;
            end else begin
               want = expected_digits.pop_front();
               if (rsp_char_code !== want.char_code) begin
                  $error("char_code: expected %h, got %h", want.char_code, rsp_char_code);
                  error_count++;
               end
               if (rsp_leading_minus !== want.leading_minus) begin
                  $error("leading_minus: expected %b, got %b", want.leading_minus,
                         rsp_leading_minus);
                  error_count++;
               end
               if (rsp_is_last !== want.is_last) begin
                  $error("is_last: expected %b, got %b", want.is_last, rsp_is_last);
                  error_count++;
               end
            end
            rsp_hold = draw_gap(rsp_calm);
         end else if (rsp_valid && rsp_hold != 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold != 0);
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Wait until every queued number is converted and every digit checked;
   // sample on the falling edge so the driver's updates have settled
   task automatic wait_idle();
      @(negedge clock);
      while (pending_numbers.size() != 0 || expected_digits.size() != 0 || req_valid) begin
         @(negedge clock);
      end
   endtask

   task automatic write_radix(input logic [RADIX_W-1:0] radix);
      wait_idle();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= radix;
      active_radix = radix;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      logic [RADIX_W-1:0] phase_radix [0:8];
      logic [63:0]        value;
      logic               op;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes at the reset radix
      pending_numbers.push_back({OP_UNSIGNED, 64'd0});
      pending_numbers.push_back({OP_SIGNED, 64'd0});
      pending_numbers.push_back({OP_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF});
      pending_numbers.push_back({OP_SIGNED, 64'hFFFF_FFFF_FFFF_FFFF});
      pending_numbers.push_back({OP_SIGNED, 64'h8000_0000_0000_0000});
      pending_numbers.push_back({OP_UNSIGNED, 64'h8000_0000_0000_0000});
      pending_numbers.push_back({OP_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF});
      pending_numbers.push_back({OP_UNSIGNED, 64'd9});
      pending_numbers.push_back({OP_UNSIGNED, 64'd10});
      pending_numbers.push_back({OP_SIGNED, 64'hFFFF_FFFF_FFFF_FFF6});

      // Directed: longest digit strings in binary
      write_radix(RADIX_MIN);
      pending_numbers.push_back({OP_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF});
      pending_numbers.push_back({OP_SIGNED, 64'h8000_0000_0000_0000});
      pending_numbers.push_back({OP_UNSIGNED, 64'd1});
      pending_numbers.push_back({OP_SIGNED, 64'd0});

      // Directed: hex digits above nine
      write_radix(RADIX_MAX);
      pending_numbers.push_back({OP_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF});
      pending_numbers.push_back({OP_UNSIGNED, 64'h0123_4567_89AB_CDEF});
      pending_numbers.push_back({OP_SIGNED, 64'hFFFF_FFFF_FFFF_FFF1});

      // Random phases: saturating radix values first, then in-range ones
      phase_radix[0] = 5'd0;
      phase_radix[1] = 5'd31;
      phase_radix[2] = 5'd1;
      phase_radix[3] = 5'd17;
      for (int p = 4; p < 8; p++) begin
         phase_radix[p] = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
      end
      phase_radix[8] = RADIX_RESET;

      for (int p = 0; p < 9; p++) begin
         write_radix(phase_radix[p]);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            op = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 5))
               0: value = {$urandom, $urandom};
               1: value = {$urandom, $urandom} >> $urandom_range(1, 63);
               2: value = 64'($urandom_range(0, 40));
               3: value = ~64'd0 - 64'($urandom_range(0, 1000));
               4: value = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 8))
                          - 64'($urandom_range(0, 8));
               default: value = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
            endcase
            pending_numbers.push_back({op, value});
         end
      end

      // Drain, then give stray beats a chance to show up
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_digits.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* integer_to_radix_digits.f */
rtl/ird_pkg.sv
rtl/ird_divider.sv
rtl/ird_sequencer.sv
rtl/integer_to_radix_digits.sv
tb/integer_to_radix_digits_tb.sv
